// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the numeric string classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define NSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks an implication on every rising clock edge, reset included.
`define NSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/nsc_pkg.sv -----
// Types and character constants for the numeric string classifier.
package nsc_pkg;

    localparam logic [7:0] CH_BLANK  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EXP_LC = 8'h65;
    localparam logic [7:0] CH_EXP_UC = 8'h45;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_AFTSIGN = 4'd1,
        PH_INT     = 4'd2,
        PH_FRAC    = 4'd3,
        PH_EXP     = 4'd4,
        PH_EXPSIGN = 4'd5,
        PH_EXPDIG  = 4'd6,
        PH_TRAIL   = 4'd7,
        PH_BAD     = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        CLS_INT  = 2'd0,
        CLS_REAL = 2'd1,
        CLS_CHAR = 2'd2
    } class_t;

    typedef struct packed {
        phase_t scan_phase;
        logic   mantissa_digit_seen;
        logic   real_mark;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        scan_phase:          PH_LEAD,
        mantissa_digit_seen: 1'b0,
        real_mark:           1'b0
    };

endpackage

// ----- rtl/nsc_step.sv -----
// Per-character scanner step: next scan state and the class on a final beat.
module nsc_step (
    input  nsc_pkg::scan_state_t cur_state,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    input  logic                 empty_string,
    output nsc_pkg::scan_state_t next_state,
    output logic                 result_valid,
    output nsc_pkg::class_t      class_code
);
    import nsc_pkg::*;

    logic        is_blank;
    logic        is_dot;
    logic        is_sign;
    logic        is_digit;
    logic        is_expo;
    scan_state_t step_state;
    logic        form_ok;

    assign is_blank = (char_code == CH_BLANK);
    assign is_dot   = (char_code == CH_DOT);
    assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_expo  = (char_code == CH_EXP_LC) || (char_code == CH_EXP_UC);

    always_comb begin
        step_state = cur_state;
        step_state.scan_phase = PH_BAD;
        unique case (cur_state.scan_phase)
            PH_LEAD, PH_AFTSIGN: begin
                if (is_blank) begin
                    step_state.scan_phase = cur_state.scan_phase;
                end else if ((cur_state.scan_phase == PH_LEAD) && is_sign) begin
                    step_state.scan_phase = PH_AFTSIGN;
                end else if (is_digit) begin
                    step_state.mantissa_digit_seen = 1'b1;
                    step_state.scan_phase = PH_INT;
                end else if (is_dot) begin
                    step_state.real_mark = 1'b1;
                    step_state.scan_phase = PH_FRAC;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    step_state.scan_phase = PH_INT;
                end else if (is_dot) begin
                    step_state.real_mark = 1'b1;
                    step_state.scan_phase = PH_FRAC;
                end else if (is_expo) begin
                    step_state.real_mark = 1'b1;
                    step_state.scan_phase = PH_EXP;
                end else if (is_blank) begin
                    step_state.scan_phase = PH_TRAIL;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    step_state.mantissa_digit_seen = 1'b1;
                    step_state.scan_phase = PH_FRAC;
                end else if (!cur_state.mantissa_digit_seen) begin
                    step_state.scan_phase = PH_BAD;
                end else if (is_expo) begin
                    step_state.real_mark = 1'b1;
                    step_state.scan_phase = PH_EXP;
                end else if (is_blank) begin
                    step_state.scan_phase = PH_TRAIL;
                end
            end
            PH_EXP: begin
                if (is_sign) begin
                    step_state.scan_phase = PH_EXPSIGN;
                end else if (is_digit) begin
                    step_state.scan_phase = PH_EXPDIG;
                end
            end
            PH_EXPSIGN: begin
                if (is_digit) begin
                    step_state.scan_phase = PH_EXPDIG;
                end
            end
            PH_EXPDIG: begin
                if (is_digit) begin
                    step_state.scan_phase = PH_EXPDIG;
                end else if (is_blank) begin
                    step_state.scan_phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (is_blank) begin
                    step_state.scan_phase = PH_TRAIL;
                end
            end
            default: begin
                step_state.scan_phase = PH_BAD;
            end
        endcase
    end

    always_comb begin
        unique case (step_state.scan_phase)
            PH_INT, PH_EXPDIG, PH_TRAIL: form_ok = 1'b1;
            PH_FRAC:                     form_ok = step_state.mantissa_digit_seen;
            default:                     form_ok = 1'b0;
        endcase
        if (empty_string || !form_ok) begin
            class_code = CLS_CHAR;
        end else if (step_state.real_mark) begin
            class_code = CLS_REAL;
        end else begin
            class_code = CLS_INT;
        end
        result_valid = last_char || empty_string;
    end

    assign next_state = result_valid ? SCAN_RESET : step_state;

endmodule

// ----- rtl/numeric_string_classifier_top.sv -----
// The scanner step is combinational, between the input register and the result register.
// Throughput: one character beat per cycle, unless a final beat waits on a stalled result register.
// An input register and a result register part the two sides, so character beats keep
// flowing while a class waits to be taken; the next final beat then waits in the input register.
// Reset: aresetn is synchronous and active low; it empties both registers and
// returns the scanner to the leading-blanks phase.
`include "assert_macros.svh"

module numeric_string_classifier_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,
    input  logic       s_axis_tuser,   // [0] empty_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] class_code, [7:2] zero
);
    import nsc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        in_empty_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    class_t      out_class_reg;
    class_t      out_class_next;

    scan_state_t step_state;
    logic        step_result;
    class_t      step_class;
    logic        advance;
    logic        in_take;

    nsc_step u_step (
        .cur_state    (state_reg),
        .char_code    (in_char_reg),
        .last_char    (in_last_reg),
        .empty_string (in_empty_reg),
        .next_state   (step_state),
        .result_valid (step_result),
        .class_code   (step_class)
    );

    assign advance       = in_valid_reg && (!step_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        state_next     = advance ? step_state : state_reg;
        out_valid_next = out_valid_reg;
        out_class_next = out_class_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && step_result) begin
            out_valid_next = 1'b1;
            out_class_next = step_class;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= SCAN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_char_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
        out_class_reg <= out_class_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_class_reg};

    `NSC_ASSERT(a_clear_after_result,
        (advance && step_result) |=> (state_reg == SCAN_RESET),
        "Scanner state not cleared after a final beat.")
    `NSC_ASSERT(a_int_has_digit,
        (state_reg.scan_phase == PH_INT) |-> state_reg.mantissa_digit_seen,
        "Integer phase without a mantissa digit.")
    `NSC_ASSERT(a_exp_is_real,
        ((state_reg.scan_phase == PH_EXP) || (state_reg.scan_phase == PH_EXPSIGN) ||
         (state_reg.scan_phase == PH_EXPDIG)) |-> state_reg.real_mark,
        "Exponent phase without the real mark.")
    `NSC_ASSERT(a_result_not_lost,
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_class_reg)),
        "Pending class was dropped or changed while stalled.")

endmodule

// ----- tb/numeric_string_classifier_top_tb.sv -----
// Self-checking testbench for the numeric string classifier: directed strings, then random ones.
`timescale 1ns / 1ps

module numeric_string_classifier_top_tb;
    import nsc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BEATS = 530;
    localparam int DIR_ROWS    = 15;

    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] text;
        logic        empty;
        logic        no_end;
        logic        typed;
        class_t      cls;
    } dir_row_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    int     snd_idle_pct = 9;
    int     rcv_idle_pct = 77;
    logic   rx_hold      = 1'b0;
    int     stall_cycles = 0;
    int     err_cnt      = 0;
    int     beats_sent   = 0;
    int     strings_sent = 0;
    int     class_hits [3] = '{0, 0, 0};
    class_t want;

    class_t     expected_class_q [$];
    logic [7:0] text_q [$];

    phase_t scan_ph   = PH_LEAD;
    logic   mant_seen = 1'b0;
    logic   real_seen = 1'b0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{3'd1, "x",     1'b1, 1'b0, 1'b1, CLS_CHAR},
        '{3'd1, "0",     1'b0, 1'b0, 1'b0, CLS_INT},
        '{3'd2, "-9",    1'b0, 1'b0, 1'b0, CLS_INT},
        '{3'd1, " ",     1'b0, 1'b0, 1'b1, CLS_CHAR},
        '{3'd1, "+",     1'b0, 1'b0, 1'b1, CLS_CHAR},
        '{3'd1, ".",     1'b0, 1'b0, 1'b1, CLS_CHAR},
        '{3'd3, ".e1",   1'b0, 1'b0, 1'b1, CLS_CHAR},
        '{3'd2, "1e",    1'b0, 1'b0, 1'b1, CLS_CHAR},
        '{3'd1, 32'h00,  1'b0, 1'b0, 1'b1, CLS_CHAR},
        '{3'd1, 32'hFF,  1'b0, 1'b0, 1'b1, CLS_CHAR},
        '{3'd4, "1E-3",  1'b0, 1'b0, 1'b0, CLS_INT},
        '{3'd2, "5.",    1'b0, 1'b0, 1'b0, CLS_INT},
        '{3'd3, ".5 ",   1'b0, 1'b0, 1'b0, CLS_INT},
        '{3'd1, "1",     1'b0, 1'b1, 1'b0, CLS_INT},
        '{3'd1, "q",     1'b1, 1'b1, 1'b1, CLS_CHAR}
    };

    numeric_string_classifier_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),   // [0] empty_string
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [1:0] class_code, [7:2] zero
    );

    always #1 aclk = ~aclk;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic is_expo(input logic [7:0] c);
        return c == CH_EXP_LC || c == CH_EXP_UC;
    endfunction

    function automatic void clear_scan();
        scan_ph   = PH_LEAD;
        mant_seen = 1'b0;
        real_seen = 1'b0;
    endfunction

    // Advances the scanner by one beat and returns 1 when the beat ends a string.
    function automatic logic scan_char(input logic [7:0] c, input logic last,
                                       input logic empty, output class_t cls);
        logic ok;
        cls = CLS_CHAR;
        if (empty) begin
            clear_scan();
            return 1'b1;
        end
        case (scan_ph)
            PH_LEAD, PH_AFTSIGN: begin
                if (c != CH_BLANK) begin
                    if (scan_ph == PH_LEAD && is_sign(c)) begin
                        scan_ph = PH_AFTSIGN;
                    end else if (is_digit(c)) begin
                        mant_seen = 1'b1;
                        scan_ph   = PH_INT;
                    end else if (c == CH_DOT) begin
                        real_seen = 1'b1;
                        scan_ph   = PH_FRAC;
                    end else begin
                        scan_ph = PH_BAD;
                    end
                end
            end
            PH_INT: begin
                if (is_digit(c)) begin
                    scan_ph = PH_INT;
                end else if (c == CH_DOT) begin
                    real_seen = 1'b1;
                    scan_ph   = PH_FRAC;
                end else if (is_expo(c)) begin
                    real_seen = 1'b1;
                    scan_ph   = PH_EXP;
                end else if (c == CH_BLANK) begin
                    scan_ph = PH_TRAIL;
                end else begin
                    scan_ph = PH_BAD;
                end
            end
            PH_FRAC: begin
                if (is_digit(c)) begin
                    mant_seen = 1'b1;
                end else if (!mant_seen) begin
                    scan_ph = PH_BAD;
                end else if (is_expo(c)) begin
                    real_seen = 1'b1;
                    scan_ph   = PH_EXP;
                end else if (c == CH_BLANK) begin
                    scan_ph = PH_TRAIL;
                end else begin
                    scan_ph = PH_BAD;
                end
            end
            PH_EXP: begin
                if (is_sign(c)) scan_ph = PH_EXPSIGN;
                else if (is_digit(c)) scan_ph = PH_EXPDIG;
                else scan_ph = PH_BAD;
            end
            PH_EXPSIGN: scan_ph = is_digit(c) ? PH_EXPDIG : PH_BAD;
            PH_EXPDIG: begin
                if (is_digit(c)) scan_ph = PH_EXPDIG;
                else if (c == CH_BLANK) scan_ph = PH_TRAIL;
                else scan_ph = PH_BAD;
            end
            PH_TRAIL: scan_ph = (c == CH_BLANK) ? PH_TRAIL : PH_BAD;
            default: scan_ph = PH_BAD;
        endcase
        if (!last) return 1'b0;
        case (scan_ph)
            PH_INT, PH_EXPDIG, PH_TRAIL: ok = 1'b1;
            PH_FRAC: ok = mant_seen;
            default: ok = 1'b0;
        endcase
        if (ok) cls = real_seen ? CLS_REAL : CLS_INT;
        clear_scan();
        return 1'b1;
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
    endfunction

    function automatic logic [7:0] form_char();
        case ($urandom_range(5))
            0: return CH_BLANK;
            1: return CH_DOT;
            2: return CH_PLUS;
            3: return CH_MINUS;
            4: return CH_EXP_LC;
            default: return CH_EXP_UC;
        endcase
    endfunction

    // Mostly well-formed numbers with random content; some get a byte replaced or inserted.
    function automatic void build_string();
        int pick;
        pick = $urandom_range(99);
        text_q.delete();
        repeat ($urandom_range(2)) text_q.push_back(CH_BLANK);
        if ($urandom_range(2) == 0) begin
            text_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            repeat ($urandom_range(1)) text_q.push_back(CH_BLANK);
        end
        push_digits($urandom_range(4));
        if ($urandom_range(99) < 40) begin
            text_q.push_back(CH_DOT);
            push_digits($urandom_range(3));
        end
        if ($urandom_range(99) < 30) begin
            text_q.push_back($urandom_range(1) ? CH_EXP_LC : CH_EXP_UC);
            if ($urandom_range(1)) text_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            push_digits(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3));
        end
        repeat ($urandom_range(2)) text_q.push_back(CH_BLANK);
        if (text_q.size() == 0) push_digits(1);
        if (pick < 15) text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        else if (pick < 25) text_q.insert($urandom_range(text_q.size()), form_char());
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic last, input logic empty,
                             input logic typed, input class_t typed_cls);
        class_t cls;
        logic   has_res;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        has_res = scan_char(ch, last, empty, cls);
        if (has_res) expected_class_q.push_back(typed ? typed_cls : cls);
        beats_sent++;
    endtask

    task automatic send_string();
        int pick;
        int cut;
        pick = $urandom_range(99);
        strings_sent++;
        if (pick < 6) begin
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0, CLS_CHAR);
        end else begin
            build_string();
            cut = (pick < 11) ? $urandom_range(text_q.size() - 1) : text_q.size();
            for (int i = 0; i < cut; i++)
                send_beat(text_q[i], i == text_q.size() - 1, 1'b0, 1'b0, CLS_CHAR);
            if (cut < text_q.size())
                send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0, CLS_CHAR);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_class_q.size() != 0);
    endtask

    task automatic log_error(input string msg);
        if (err_cnt < 10) $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge aclk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_class_q.size() == 0) begin
                log_error($sformatf("unexpected result beat, tdata 0x%02h", m_axis_tdata));
            end else begin
                want = expected_class_q.pop_front();
                class_hits[want]++;
                if (m_axis_tdata[1:0] !== want)
                    log_error($sformatf("class_code expected %0d (%s), got %0d",
                                        want, want.name(), m_axis_tdata[1:0]));
                if (m_axis_tdata[7:2] !== 6'd0)
                    log_error($sformatf("pad bits expected 0, got tdata 0x%02h", m_axis_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int phase_end;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            strings_sent++;
            for (int i = 0; i < dir_rows[r].len; i++)
                send_beat(dir_rows[r].text[8 * (dir_rows[r].len - 1 - i) +: 8],
                          (i == dir_rows[r].len - 1) && !dir_rows[r].no_end,
                          dir_rows[r].empty, dir_rows[r].typed, dir_rows[r].cls);
        end
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                snd_idle_pct = 77;
                rcv_idle_pct <= 9;
            end else if (ph == 2) begin
                snd_idle_pct = 0;
                rcv_idle_pct <= 0;
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) send_string();
            drain_results();
        end

        repeat (8) @(posedge aclk);
        $display("Sent %0d character beats in %0d strings, with empty, aborted and corrupted ones.",
                 beats_sent, strings_sent);
        $display("Checked %0d classes: %0d integer, %0d real, %0d non-numeric; %0d errors.",
                 class_hits[0] + class_hits[1] + class_hits[2],
                 class_hits[0], class_hits[1], class_hits[2], err_cnt);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nsc_pkg.sv
rtl/nsc_step.sv
rtl/numeric_string_classifier_top.sv
tb/numeric_string_classifier_top_tb.sv
